/* hw/rtl/tlca_pkg.sv */
// ----------------------------------------------------------------------------
// tlca_pkg
// Types, sizes and the control store of the binary-lifting LCA unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tlca_pkg;

  localparam int NODE_W   = 10;
  localparam int NODES    = 1 << NODE_W;
  localparam int LEVELS   = 11;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int HEIGHT_W = 10;
  localparam int DEPTH_W  = 48;
  localparam int DIST_W   = DEPTH_W + 1;
  localparam int CMP_W    = ((HEIGHT_W > LEVELS) ? HEIGHT_W : LEVELS) + 1;
  localparam int JADDR_W  = NODE_W + LVL_W;
  localparam int PC_W     = 5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                command;
    logic [NODE_W-1:0]   first_node;
    logic [NODE_W-1:0]   second_node;
    logic [HEIGHT_W-1:0] node_height;
    logic [DEPTH_W-1:0]  node_depth;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor_node;
    logic [DIST_W-1:0] tree_distance;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LD_ROOT,
    OP_LD_RD,
    OP_LD_WR,
    OP_Q_START,
    OP_Q_ORDER,
    OP_LIFT_RD,
    OP_LIFT_A,
    OP_LIFT_H,
    OP_LVL_DEC,
    OP_EQ_CHK,
    OP_MEET_RD,
    OP_MEET_STEP,
    OP_FIN_RD,
    OP_FIN_ANC,
    OP_D_RD_F,
    OP_D_RD_S,
    OP_D_RD_ANC,
    OP_D_SUB,
    OP_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_REQ,
    C_QUERY,
    C_LOAD_DONE,
    C_LVL_MORE,
    C_NO_LIFT,
    C_LVL_NZ,
    C_A_EQ_B,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] S_IDLE   = 5'd0;
  localparam logic [PC_W-1:0] S_DISP   = 5'd1;
  localparam logic [PC_W-1:0] S_L0     = 5'd2;
  localparam logic [PC_W-1:0] S_L1     = 5'd3;
  localparam logic [PC_W-1:0] S_L2     = 5'd4;
  localparam logic [PC_W-1:0] S_L3     = 5'd5;
  localparam logic [PC_W-1:0] S_Q0     = 5'd6;
  localparam logic [PC_W-1:0] S_Q1     = 5'd7;
  localparam logic [PC_W-1:0] S_LA     = 5'd8;
  localparam logic [PC_W-1:0] S_LB     = 5'd9;
  localparam logic [PC_W-1:0] S_LC     = 5'd10;
  localparam logic [PC_W-1:0] S_LD     = 5'd11;
  localparam logic [PC_W-1:0] S_E0     = 5'd12;
  localparam logic [PC_W-1:0] S_M0     = 5'd13;
  localparam logic [PC_W-1:0] S_M1     = 5'd14;
  localparam logic [PC_W-1:0] S_F0     = 5'd15;
  localparam logic [PC_W-1:0] S_F1     = 5'd16;
  localparam logic [PC_W-1:0] S_D0     = 5'd17;
  localparam logic [PC_W-1:0] S_D1     = 5'd18;
  localparam logic [PC_W-1:0] S_D2     = 5'd19;
  localparam logic [PC_W-1:0] S_D3     = 5'd20;
  localparam logic [PC_W-1:0] S_OUT    = 5'd21;
  localparam logic [PC_W-1:0] S_BACK   = 5'd22;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    case (pc)
      S_IDLE: w = '{op: OP_ACCEPT,    cond: C_NO_REQ,    target: S_IDLE};
      S_DISP: w = '{op: OP_NONE,      cond: C_QUERY,     target: S_Q0};
      S_L0:   w = '{op: OP_LD_ROOT,   cond: C_LOAD_DONE, target: S_IDLE};
      S_L1:   w = '{op: OP_LD_RD,     cond: C_NONE,      target: S_IDLE};
      S_L2:   w = '{op: OP_LD_WR,     cond: C_LVL_MORE,  target: S_L1};
      S_L3:   w = '{op: OP_NONE,      cond: C_ALWAYS,    target: S_IDLE};
      S_Q0:   w = '{op: OP_Q_START,   cond: C_NONE,      target: S_IDLE};
      S_Q1:   w = '{op: OP_Q_ORDER,   cond: C_NONE,      target: S_IDLE};
      S_LA:   w = '{op: OP_LIFT_RD,   cond: C_NO_LIFT,   target: S_LD};
      S_LB:   w = '{op: OP_LIFT_A,    cond: C_NONE,      target: S_IDLE};
      S_LC:   w = '{op: OP_LIFT_H,    cond: C_NONE,      target: S_IDLE};
      S_LD:   w = '{op: OP_LVL_DEC,   cond: C_LVL_NZ,    target: S_LA};
      S_E0:   w = '{op: OP_EQ_CHK,    cond: C_A_EQ_B,    target: S_D0};
      S_M0:   w = '{op: OP_MEET_RD,   cond: C_NONE,      target: S_IDLE};
      S_M1:   w = '{op: OP_MEET_STEP, cond: C_LVL_NZ,    target: S_M0};
      S_F0:   w = '{op: OP_FIN_RD,    cond: C_NONE,      target: S_IDLE};
      S_F1:   w = '{op: OP_FIN_ANC,   cond: C_NONE,      target: S_IDLE};
      S_D0:   w = '{op: OP_D_RD_F,    cond: C_NONE,      target: S_IDLE};
      S_D1:   w = '{op: OP_D_RD_S,    cond: C_NONE,      target: S_IDLE};
      S_D2:   w = '{op: OP_D_RD_ANC,  cond: C_NONE,      target: S_IDLE};
      S_D3:   w = '{op: OP_D_SUB,     cond: C_NONE,      target: S_IDLE};
      S_OUT:  w = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: S_OUT};
      S_BACK: w = '{op: OP_NONE,      cond: C_ALWAYS,    target: S_IDLE};
      default: w = '{op: OP_NONE,     cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tree_lca_binary_lifting_unit.sv */
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_unit
// Binary-lifting ancestor table with LCA and weighted distance queries,
// run by a small microprogram over a plain datapath.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  request | in  | in_valid / in_ready  | in_data  (req_t)
//  result  | out | out_valid / out_ready| out_data (rsp_t)
//
//  One request at a time; in_ready is high only at the idle step.
//  Load: one jump-table read per level; a load of node 0 writes nothing
//  and returns to idle after its first step.
//  Query: two passes over LEVELS levels; in the lift pass level LEVELS-1
//  never lifts, and the meet pass is skipped when the lifted nodes
//  already match.
//  Result sits in an output register; the program stalls at its emit step
//  only while the previous result is still untaken. Sync reset, no clearing
//  pass: node 0 reads as zero by address decode.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_lca_binary_lifting_unit import tlca_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);

  logic [NODE_W-1:0]   jump_mem [NODES * (1 << LVL_W)];
  logic [HEIGHT_W-1:0] height_mem [NODES];
  logic [DEPTH_W-1:0]  depth_mem [NODES];

  logic [PC_W-1:0] pc, pc_next;
  uword_t          uw;
  logic            jump_taken;

  logic                cmd;
  logic [NODE_W-1:0]   f_node, s_node;
  logic [HEIGHT_W-1:0] ld_height;
  logic [DEPTH_W-1:0]  ld_depth;
  logic [NODE_W-1:0]   a, b, cur, anc;
  logic [HEIGHT_W-1:0] ha, hb;
  logic [LVL_W-1:0]    lvl;
  logic [DIST_W-1:0]   acc;

  logic [JADDR_W-1:0]  jaddr_a, jaddr_b, jwaddr;
  logic [NODE_W-1:0]   jwdata;
  logic                jwe;
  logic [NODE_W-1:0]   jq_a, jq_b, jd_a, jd_b;
  logic                jz_a, jz_b;
  logic [NODE_W-1:0]   haddr_a, haddr_b;
  logic [HEIGHT_W-1:0] hq_a, hq_b, hd_a, hd_b;
  logic                hz_a, hz_b;
  logic [NODE_W-1:0]   daddr;
  logic [DEPTH_W-1:0]  dq, dd;
  logic                dz;
  logic                wr_node;
  logic [CMP_W-1:0]    lift_lim;

  assign uw       = ucode(pc);
  assign in_ready = (uw.op == OP_ACCEPT);
  assign wr_node  = (uw.op == OP_LD_ROOT) && (s_node != '0);

  assign jd_a = jz_a ? '0 : jq_a;
  assign jd_b = jz_b ? '0 : jq_b;
  assign hd_a = hz_a ? '0 : hq_a;
  assign hd_b = hz_b ? '0 : hq_b;
  assign dd   = dz ? '0 : dq;

  assign lift_lim = CMP_W'(hb) + (CMP_W'(1) << lvl);

  // sequencer
  always_comb begin
    case (uw.cond)
      C_NONE:      jump_taken = 1'b0;
      C_ALWAYS:    jump_taken = 1'b1;
      C_NO_REQ:    jump_taken = !in_valid;
      C_QUERY:     jump_taken = (cmd == CMD_QUERY);
      C_LOAD_DONE: jump_taken = (s_node == '0) || (LEVELS == 1);
      C_LVL_MORE:  jump_taken = (lvl != LVL_W'(LEVELS - 1));
      C_NO_LIFT:   jump_taken = (CMP_W'(ha) < lift_lim);
      C_LVL_NZ:    jump_taken = (lvl != '0);
      C_A_EQ_B:    jump_taken = (a == b);
      C_OUT_BUSY:  jump_taken = out_valid && !out_ready;
      default:     jump_taken = 1'b0;
    endcase
    pc_next = jump_taken ? uw.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // memory port control
  always_comb begin
    jaddr_a = {a, lvl};
    jaddr_b = {b, lvl};
    jwaddr  = {s_node, lvl};
    jwdata  = jd_a;
    jwe     = 1'b0;
    haddr_a = f_node;
    haddr_b = s_node;
    daddr   = f_node;
    case (uw.op)
      OP_LD_ROOT: begin
        jwaddr = {s_node, LVL_W'(0)};
        jwdata = f_node;
        jwe    = wr_node;
      end
      OP_LD_RD:    jaddr_a = {cur, lvl - LVL_W'(1)};
      OP_LD_WR:    jwe = 1'b1;
      OP_LIFT_A:   haddr_a = jd_a;
      OP_FIN_RD:   jaddr_a = {a, LVL_W'(0)};
      OP_D_RD_S:   daddr = s_node;
      OP_D_RD_ANC: daddr = anc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    jq_a <= jump_mem[jaddr_a];
    jq_b <= jump_mem[jaddr_b];
    if (jwe) begin
      jump_mem[jwaddr] <= jwdata;
    end
  end

  always_ff @(posedge clk) begin
    hq_a <= height_mem[haddr_a];
    hq_b <= height_mem[haddr_b];
    if (wr_node) begin
      height_mem[s_node] <= ld_height;
    end
  end

  always_ff @(posedge clk) begin
    dq <= depth_mem[daddr];
    if (wr_node) begin
      depth_mem[s_node] <= ld_depth;
    end
  end

  // node 0 is the sentinel: its row, height and depth read as zero
  always_ff @(posedge clk) begin
    jz_a <= (jaddr_a[JADDR_W-1 -: NODE_W] == '0);
    jz_b <= (jaddr_b[JADDR_W-1 -: NODE_W] == '0);
    hz_a <= (haddr_a == '0);
    hz_b <= (haddr_b == '0);
    dz   <= (daddr == '0);
  end

  // datapath
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_ACCEPT: begin
        if (in_valid) begin
          cmd       <= in_data.command;
          f_node    <= in_data.first_node;
          s_node    <= in_data.second_node;
          ld_height <= in_data.node_height;
          ld_depth  <= in_data.node_depth;
        end
      end
      OP_LD_ROOT: begin
        cur <= f_node;
        lvl <= LVL_W'(1);
      end
      OP_LD_WR: begin
        cur <= jd_a;
        lvl <= lvl + LVL_W'(1);
      end
      OP_Q_START: begin
        a <= f_node;
        b <= s_node;
      end
      OP_Q_ORDER: begin
        lvl <= LVL_W'(LEVELS - 1);
        if (hd_a < hd_b) begin
          a  <= b;
          b  <= a;
          ha <= hd_b;
          hb <= hd_a;
        end else begin
          ha <= hd_a;
          hb <= hd_b;
        end
      end
      OP_LIFT_A:  a <= jd_a;
      OP_LIFT_H:  ha <= hd_a;
      OP_LVL_DEC: lvl <= lvl - LVL_W'(1);
      OP_EQ_CHK: begin
        anc <= a;
        lvl <= LVL_W'(LEVELS - 1);
      end
      OP_MEET_STEP: begin
        lvl <= lvl - LVL_W'(1);
        if (jd_a != jd_b) begin
          a <= jd_a;
          b <= jd_b;
        end
      end
      OP_FIN_ANC:  anc <= jd_a;
      OP_D_RD_S:   acc <= {1'b0, dd};
      OP_D_RD_ANC: acc <= acc + {1'b0, dd};
      OP_D_SUB:    acc <= acc - {dd, 1'b0};
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == OP_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT && (!out_valid || out_ready)) begin
      out_data.ancestor_node <= anc;
      out_data.tree_distance <= acc;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the binary-lifting LCA unit. Builds trees by node loads
// (parents before children), asks ancestor/distance queries, and checks each
// answer against a local model of the jump table or a fixed answer. Short
// directed rows cover the sentinel, extremes, ignored loads, self-parent and
// inconsistent trees; a long random run then idles at random on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import tlca_pkg::*;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct {
    req_t  req;
    bit    fixed;
    node_t want_anc;
    dist_t want_dist;
  } step_row_t;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 100;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  req_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  rsp_t out_data;

  tree_lca_binary_lifting_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // local copy of the tree
  node_t               anc_rows  [NODES][LEVELS];
  logic [HEIGHT_W-1:0] height_of [NODES];
  logic [DEPTH_W-1:0]  depth_of  [NODES];
  bit                  is_loaded [NODES];

  rsp_t  pending_answers[$];
  node_t known_nodes[$];
  node_t fresh_ids[$];

  bit          steady;
  int unsigned mismatch_count  = 0;
  int unsigned answers_checked = 0;
  int unsigned loads_done;
  int unsigned queries_done;
  int unsigned quiet_cycles    = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic insert_tree_node(input node_t parent, input node_t child,
                                  input logic [HEIGHT_W-1:0] h,
                                  input logic [DEPTH_W-1:0] d);
    if (child == '0)
      return;
    anc_rows[child][0] = parent;
    for (int i = 1; i < LEVELS; i++)
      anc_rows[child][i] = anc_rows[anc_rows[child][i-1]][i-1];
    height_of[child] = h;
    depth_of[child]  = d;
    is_loaded[child] = 1'b1;
  endtask

  function automatic rsp_t lca_and_distance(input node_t a, input node_t b);
    node_t x;
    node_t y;
    node_t t;
    rsp_t  r;
    x = a;
    y = b;
    if (height_of[x] < height_of[y]) begin
      t = x;
      x = y;
      y = t;
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (int'(height_of[x]) >= int'(height_of[y]) + (1 << i))
        x = anc_rows[x][i];
    end
    if (x == y) begin
      r.ancestor_node = x;
    end else begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (anc_rows[x][i] != anc_rows[y][i]) begin
          x = anc_rows[x][i];
          y = anc_rows[y][i];
        end
      end
      r.ancestor_node = anc_rows[x][0];
    end
    r.tree_distance = DIST_W'(depth_of[a]) + DIST_W'(depth_of[b])
                      - (DIST_W'(depth_of[r.ancestor_node]) << 1);
    return r;
  endfunction

  function automatic node_t pick_known();
    return known_nodes[$urandom_range(known_nodes.size() - 1)];
  endfunction

  function automatic step_row_t mk(input logic cmd, input node_t first,
                                   input node_t second,
                                   input logic [HEIGHT_W-1:0] h,
                                   input logic [DEPTH_W-1:0] d,
                                   input bit fixed = 1'b0,
                                   input node_t anc = '0,
                                   input dist_t span = '0);
    step_row_t s;
    s.req.command     = cmd;
    s.req.first_node  = first;
    s.req.second_node = second;
    s.req.node_height = h;
    s.req.node_depth  = d;
    s.fixed           = fixed;
    s.want_anc        = anc;
    s.want_dist       = span;
    return s;
  endfunction

  // drive one request, wait for its handshake, then update the model
  task automatic issue(input req_t r, input bit fixed, input rsp_t given);
    rsp_t expected;
    if (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.command == CMD_QUERY) begin
      expected = fixed ? given : lca_and_distance(r.first_node, r.second_node);
      pending_answers = {pending_answers, expected};
      queries_done++;
    end else begin
      if (r.second_node != '0 && !is_loaded[r.second_node])
        known_nodes = {known_nodes, r.second_node};
      insert_tree_node(r.first_node, r.second_node, r.node_height, r.node_depth);
      loads_done++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin : answer_check
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no pending query", 64'(out_data), '0);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.ancestor_node !== want.ancestor_node)
          report_mismatch("ancestor_node", 64'(out_data.ancestor_node),
                          64'(want.ancestor_node));
        if (out_data.tree_distance !== want.tree_distance)
          report_mismatch("tree_distance", 64'(out_data.tree_distance),
                          64'(want.tree_distance));
        answers_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tree_lca_binary_lifting_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    step_row_t plan[$];
    req_t      r;
    rsp_t      given;
    node_t     deep_node;
    node_t     last_node;
    int        idx;
    int        roll;
    bit        noise;
    int        tallest;

    for (int v = 0; v < NODES; v++) begin
      for (int l = 0; l < LEVELS; l++)
        anc_rows[v][l] = '0;
      height_of[v] = '0;
      depth_of[v]  = '0;
      is_loaded[v] = 1'b0;
    end
    is_loaded[0] = 1'b1;
    known_nodes = {known_nodes, node_t'(0)};
    steady          = 1'b0;
    loads_done      = 0;
    queries_done    = 0;
    tallest         = 0;

    //               cmd        first    second   height   depth
    plan = {plan, mk(CMD_QUERY, 10'd0,   10'd0,   10'd0,   48'd0, 1, 10'd0, 49'd0)};
    plan = {plan, mk(CMD_LOAD,  10'd1023, 10'd0,  10'd1023, '1)};
    plan = {plan, mk(CMD_QUERY, 10'd0,   10'd0,   10'd0,   48'd0, 1, 10'd0, 49'd0)};
    plan = {plan, mk(CMD_LOAD,  10'd0,   10'd1023, 10'd0,  48'd0)};
    plan = {plan, mk(CMD_LOAD,  10'd1023, 10'd1,  10'd1,   '1)};
    plan = {plan, mk(CMD_QUERY, 10'd0,   10'd1,   10'd0,   48'd0, 1, 10'd0,
                     49'hFFFF_FFFF_FFFF)};
    plan = {plan, mk(CMD_QUERY, 10'd1023, 10'd1023, 10'd0, 48'd0, 1, 10'd1023, 49'd0)};
    plan = {plan, mk(CMD_LOAD,  10'd1,   10'd2,   10'd2,   48'd5)};
    plan = {plan, mk(CMD_LOAD,  10'd1023, 10'd512, 10'd1,  48'd7)};
    plan = {plan, mk(CMD_QUERY, 10'd2,   10'd512, 10'd0,   48'd0)};
    plan = {plan, mk(CMD_QUERY, 10'd1,   10'd2,   10'd0,   48'd0)};
    plan = {plan, mk(CMD_LOAD,  10'd2,   10'd3,   10'd1023, 48'h8000_0000_0000)};
    plan = {plan, mk(CMD_QUERY, 10'd3,   10'd512, 10'd0,   48'd0)};
    plan = {plan, mk(CMD_QUERY, 10'd3,   10'd0,   10'd0,   48'd0)};
    plan = {plan, mk(CMD_LOAD,  10'd1000, 10'd1000, 10'd3, 48'd100)};
    plan = {plan, mk(CMD_QUERY, 10'd1000, 10'd1023, 10'd0, 48'd0)};
    plan = {plan, mk(CMD_LOAD,  10'd0,   10'h155, 10'h2AA, 48'hAAAA_AAAA_AAAA)};
    plan = {plan, mk(CMD_LOAD,  10'h155, 10'h2AA, 10'h155, 48'h5555_5555_5555)};
    plan = {plan, mk(CMD_QUERY, 10'h2AA, 10'h155, 10'd0,   48'd0)};
    plan = {plan, mk(CMD_LOAD,  10'd1023, 10'd2,  10'd1,   48'd9)};
    plan = {plan, mk(CMD_QUERY, 10'd3,   10'd1,   10'd0,   48'd0)};
    plan = {plan, mk(CMD_QUERY, 10'd2,   10'd2,   10'd0,   48'd0, 1, 10'd2, 49'd0)};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      given.ancestor_node = plan[k].want_anc;
      given.tree_distance = plan[k].want_dist;
      issue(plan[k].req, plan[k].fixed, given);
    end

    for (int v = 1; v < NODES; v++)
      if (!is_loaded[v])
        fresh_ids = {fresh_ids, node_t'(v)};
    deep_node = 10'd1;
    last_node = 10'd2;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 550);
      r = '0;
      if ($urandom_range(99) < 35) begin
        r.command     = CMD_QUERY;
        r.first_node  = pick_known();
        r.second_node = ($urandom_range(99) < 15) ? r.first_node : pick_known();
        issue(r, 1'b0, '0);
      end else begin
        noise     = ($urandom_range(99) >= 85);
        r.command = CMD_LOAD;
        if (fresh_ids.size() > 0 && $urandom_range(99) < 88) begin
          idx           = $urandom_range(fresh_ids.size() - 1);
          r.second_node = fresh_ids[idx];
          fresh_ids.delete(idx);
        end else begin
          r.second_node = pick_known();
        end
        roll = $urandom_range(99);
        r.first_node = (roll < 55) ? deep_node :
                       (roll < 75) ? last_node :
                       (roll < 95) ? pick_known() : node_t'(0);
        if (noise) begin
          r.node_height = HEIGHT_W'($urandom);
          r.node_depth  = DEPTH_W'({$urandom, $urandom});
        end else begin
          r.node_height = height_of[r.first_node] + 1'b1;
          r.node_depth  = depth_of[r.first_node]
                          + (DEPTH_W'({$urandom, $urandom}) >> $urandom_range(0, DEPTH_W - 1));
        end
        issue(r, 1'b0, '0);
        last_node = r.second_node;
        if (!noise && r.second_node != '0 &&
            height_of[r.second_node] >= height_of[deep_node]) begin
          deep_node = r.second_node;
          if (int'(height_of[deep_node]) > tallest)
            tallest = int'(height_of[deep_node]);
        end
      end
    end
    steady   = 1'b0;
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d node loads, %0d queries, %0d answers compared.",
             loads_done, queries_done, answers_checked);
    $display("Tree: %0d distinct nodes, tallest consistent chain %0d, %0d mismatches.",
             known_nodes.size() - 1, tallest, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tree_lca_binary_lifting_unit test passed");
    end else begin
      $display("tree_lca_binary_lifting_unit test failed");
    end
    $finish;
  end

endmodule
